### rtl/convolutional_encoder_top_macros.svh
`ifndef CONVOLUTIONAL_ENCODER_TOP_MACROS_SVH
`define CONVOLUTIONAL_ENCODER_TOP_MACROS_SVH

// same-cycle check, sampled on clk_i, off while rst_ni is low
`define CENC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cenc check failed");

// next-cycle check, sampled on clk_i, off while rst_ni is low
`define CENC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cenc next-cycle check failed");

`endif

### rtl/cenc_pkg.sv
package cenc_pkg;

  // code shape
  localparam int MaxGenerators = 5;
  localparam int MaxConstraint = 9;
  localparam int StateW        = MaxConstraint - 1;
  localparam int GenW          = MaxConstraint;
  localparam int CodeW         = MaxGenerators;
  localparam int KW            = 4;
  localparam int NW            = 3;
  localparam int CntW          = 4;

  // register port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 9;

  // reset values
  localparam logic [KW-1:0]   KReset    = 4'd7;
  localparam logic [NW-1:0]   NReset    = 3'd2;
  localparam logic [GenW-1:0] Gen0Reset = 9'o171;
  localparam logic [GenW-1:0] Gen1Reset = 9'o133;

  // command queue
  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int QCntW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegK    = 3'd0,
    RegN    = 3'd1,
    RegGen0 = 3'd2,
    RegGen1 = 3'd3,
    RegGen2 = 3'd4,
    RegGen3 = 3'd5,
    RegGen4 = 3'd6
  } reg_idx_e;

  typedef enum logic {
    OpEncode = 1'b0,
    OpFlush  = 1'b1
  } op_e;

  // effective configuration, already clamped
  typedef struct packed {
    logic [KW-1:0]                       k;
    logic [NW-1:0]                       n;
    logic [MaxGenerators-1:0][GenW-1:0]  gen;
  } cfg_t;

  typedef struct packed {
    op_e             op;
    logic            data_bit;
    logic [CntW-1:0] count;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic fire;
    logic pop;
  } back_stat_t;

endpackage

### rtl/cenc_if.sv
interface cenc_in_if;
  logic valid;
  logic ready;
  logic func;
  logic data_bit;

  modport source (output valid, output func, output data_bit, input ready);
  modport sink   (input valid, input func, input data_bit, output ready);
endinterface

interface cenc_out_if;
  import cenc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code_bits;
  logic             last;

  modport source (output valid, output code_bits, output last, input ready);
  modport sink   (input valid, input code_bits, input last, output ready);
endinterface

interface cenc_cfg_if;
  import cenc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/cenc_regs.sv
module cenc_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  cenc_cfg_if.sink      cfg_i,
  output cenc_pkg::cfg_t cfg_o
);
  import cenc_pkg::*;

  logic [KW-1:0]                      k_q;
  logic [NW-1:0]                      n_q;
  logic [MaxGenerators-1:0][GenW-1:0] gen_q;

  assign cfg_i.ready = 1'b1;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= KReset;
      n_q    <= NReset;
      gen_q  <= {GenW'(0), GenW'(0), GenW'(0), Gen1Reset, Gen0Reset};
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegK:    k_q      <= cfg_i.data[KW-1:0];
        RegN:    n_q      <= cfg_i.data[NW-1:0];
        RegGen0: gen_q[0] <= cfg_i.data[GenW-1:0];
        RegGen1: gen_q[1] <= cfg_i.data[GenW-1:0];
        RegGen2: gen_q[2] <= cfg_i.data[GenW-1:0];
        RegGen3: gen_q[3] <= cfg_i.data[GenW-1:0];
        RegGen4: gen_q[4] <= cfg_i.data[GenW-1:0];
        default: ;
      endcase
    end
  end

  // clamp k and n into their working ranges
  always_comb begin
    cfg_o.gen = gen_q;
    if (k_q < KW'(2))                  cfg_o.k = KW'(2);
    else if (k_q > KW'(MaxConstraint)) cfg_o.k = KW'(MaxConstraint);
    else                               cfg_o.k = k_q;
    if (n_q == '0)                     cfg_o.n = NW'(1);
    else if (n_q > NW'(MaxGenerators)) cfg_o.n = NW'(MaxGenerators);
    else                               cfg_o.n = n_q;
  end

endmodule

### rtl/cenc_front.sv
module cenc_front (
  cenc_in_if.sink         in_i,
  input  cenc_pkg::cfg_t  cfg_i,
  input  cenc_pkg::q_stat_t q_stat_i,
  output cenc_pkg::push_t push_o
);
  import cenc_pkg::*;

  assign in_i.ready = !q_stat_i.full;

  // classify the item and work out how many groups it produces
  always_comb begin
    push_o.push           = in_i.valid && !q_stat_i.full;
    push_o.entry.data_bit = in_i.data_bit;
    if (in_i.func) begin
      push_o.entry.op    = OpFlush;
      push_o.entry.count = CntW'(cfg_i.k - KW'(1));
    end else begin
      push_o.entry.op    = OpEncode;
      push_o.entry.count = CntW'(1);
    end
  end

endmodule

### rtl/cenc_fifo.sv
module cenc_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cenc_pkg::push_t       push_i,
  input  logic                  pop_i,
  output cenc_pkg::q_entry_t    head_o,
  output cenc_pkg::q_stat_t     stat_o
);
  import cenc_pkg::*;

  q_entry_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && !stat_o.empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i.push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.push && !do_pop)      cnt_d = cnt_q + QCntW'(1);
    else if (!push_i.push && do_pop) cnt_d = cnt_q - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

### rtl/cenc_back.sv
module cenc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cenc_pkg::cfg_t       cfg_i,
  input  cenc_pkg::q_entry_t   head_i,
  input  cenc_pkg::q_stat_t    q_stat_i,
  output cenc_pkg::back_stat_t stat_o,
  cenc_out_if.source           out_o
);
  import cenc_pkg::*;

  logic [StateW-1:0]        state_q, state_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;
  logic [CodeW-1:0]         code_q, code_d;
  logic                     last_q, last_d;
  logic                     advance;
  logic                     is_last;
  logic                     cur_bit;
  logic [KW-1:0]            km1, km2;
  logic [MaxConstraint-1:0] state_ext;
  logic [MaxConstraint-1:0] word;
  logic [StateW-1:0]        shifted_state;

  assign out_o.valid     = out_valid_q;
  assign out_o.code_bits = code_q;
  assign out_o.last      = last_q;

  // handshake with the queue and the output register
  assign advance     = !out_valid_q || out_o.ready;
  assign stat_o.fire = advance && !q_stat_i.empty;
  assign is_last     = (head_i.op == OpEncode) || ((cnt_q + CntW'(1)) == head_i.count);
  assign stat_o.pop  = stat_o.fire && is_last;

  // register word and shifted state
  always_comb begin
    cur_bit   = (head_i.op == OpEncode) ? head_i.data_bit : 1'b0;
    km1       = cfg_i.k - KW'(1);
    km2       = cfg_i.k - KW'(2);
    state_ext = {1'b0, state_q};
    for (int i = 0; i < MaxConstraint; i++) begin
      if (KW'(i) == km1)     word[i] = cur_bit;
      else if (KW'(i) < km1) word[i] = state_ext[i];
      else                   word[i] = 1'b0;
    end
    for (int i = 0; i < StateW; i++) begin
      if (KW'(i) == km2)     shifted_state[i] = cur_bit;
      else if (KW'(i) < km2) shifted_state[i] = state_ext[i+1];
      else                   shifted_state[i] = 1'b0;
    end
  end

  // one parity tree per generator
  always_comb begin
    code_d = '0;
    for (int j = 0; j < MaxGenerators; j++) begin
      if (NW'(j) < cfg_i.n) code_d[j] = ^(word & cfg_i.gen[j]);
    end
  end

  // next values of control state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    last_d      = is_last;
    if (stat_o.fire) begin
      state_d     = shifted_state;
      cnt_d       = is_last ? '0 : cnt_q + CntW'(1);
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (stat_o.fire) begin
      code_q <= code_d;
      last_q <= last_d;
    end
  end

endmodule

### rtl/convolutional_encoder_top.sv
// convolutional encoder, rate 1/n, K from 2 to 9, up to five generators
// an item goes through the command queue, then its groups through the output register
// throughput: one encode item per cycle unless out_o stalls; a flush takes K-1 groups
// the two-entry command queue lets input items arrive while a flush drains
// reset: K = 7, two generators 171/133 octal, shift state zero, queue and output empty
`include "convolutional_encoder_top_macros.svh"

module convolutional_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  cenc_in_if.sink    in_i,
  cenc_out_if.source out_o,
  cenc_cfg_if.sink   cfg_i
);
  import cenc_pkg::*;

  cfg_t       cfg;
  push_t      push;
  q_entry_t   head;
  q_stat_t    q_stat;
  back_stat_t back_stat;

  // configuration registers
  cenc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // item intake and classification
  cenc_front u_front (
    .in_i     (in_i),
    .cfg_i    (cfg),
    .q_stat_i (q_stat),
    .push_o   (push)
  );

  // command queue
  cenc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (back_stat.pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // encoder core and output register
  cenc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .head_i   (head),
    .q_stat_i (q_stat),
    .stat_o   (back_stat),
    .out_o    (out_o)
  );

  // checks
  `CENC_ASSERT(a_q_stat_sane, 1'b1, !(q_stat.full && q_stat.empty))
  `CENC_ASSERT(a_unused_bits_zero, out_o.valid, (out_o.code_bits >> cfg.n) == '0)
  `CENC_ASSERT_NEXT(a_flush_keeps_entry, back_stat.fire && !back_stat.pop, !q_stat.empty)

endmodule
